/* rtl/core/kpt_pkg.sv */
// Shared types and constants for the three-axis Kalman position tracker.
`timescale 1ns / 1ps

package kpt_pkg;

   localparam int NUM_AXES   = 3;
   localparam int POS_W      = 32;
   localparam int COV_W      = 48;
   localparam int DT_W       = 24;
   localparam int LIM_W      = 16;
   localparam int COV_FRAC   = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [COV_W-1:0] COV_INIT = COV_W'(10) << COV_FRAC;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_POS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_CROSS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_VEL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_VAR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_LIMIT = 3'd5;

   typedef struct packed {
      logic [DT_W-1:0]  step_time;
      logic [COV_W-1:0] q_pos;
      logic [COV_W-1:0] q_cross;
      logic [COV_W-1:0] q_vel;
      logic [COV_W-1:0] meas_var;
   } kpt_cfg_type;

   typedef struct packed {
      logic start;
      logic load_meas;
      logic init;
   } kpt_lane_ctl_type;

endpackage

/* rtl/core/kpt_lane.sv */
// One axis of the tracker: a two-state filter run by a sequencer over a shared
// multiplier and a one-bit-per-cycle divider.
`timescale 1ns / 1ps

module kpt_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  kpt_pkg::kpt_lane_ctl_type           ctl,
   input  kpt_pkg::kpt_cfg_type                cfg,
   input  logic signed [kpt_pkg::POS_W-1:0]    meas,
   output logic                                busy,
   output logic signed [kpt_pkg::POS_W-1:0]    held_pos,
   output logic signed [kpt_pkg::POS_W-1:0]    held_vel
);
   import kpt_pkg::*;

   localparam int PROD_W = 97;   // 96-bit product plus rounding bias
   localparam int MREG_W = 72;   // 48 x 24 partial product
   localparam int QUO_W  = 61;   // quotient bits kept; anything larger saturates
   localparam int RES_W  = 62;   // signed result, magnitude at most 2^60
   localparam int S_W    = 49;
   localparam int Y_W    = 33;
   localparam int HALF   = 24;
   localparam int CNT_W  = 6;

   localparam logic [1:0] SH_0  = 2'd0;
   localparam logic [1:0] SH_16 = 2'd1;
   localparam logic [1:0] SH_32 = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_ACC, ST_POST, ST_DIV, ST_SUMS
   } lane_state_type;

   typedef enum logic [3:0] {
      OP_DTSQ, OP_VDT, OP_P01DT, OP_P11DTSQ, OP_P11DT,
      OP_GX, OP_GV, OP_P11G, OP_P00G, OP_P01G
   } op_type;

   function automatic logic signed [POS_W-1:0] sat_s32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         return 32'sh80000000;
      else
         return v[POS_W-1:0];
   endfunction

   function automatic logic [COV_W-1:0] sat_u48(input logic signed [63:0] v);
      if (v < 64'sd0)
         return '0;
      else if (v > 64'sd281474976710655)
         return '1;
      else
         return v[COV_W-1:0];
   endfunction

   function automatic logic signed [COV_W-1:0] sat_s48(input logic signed [63:0] v);
      if (v > 64'sd140737488355327)
         return 48'sh7FFFFFFFFFFF;
      else if (v < -64'sd140737488355328)
         return 48'sh800000000000;
      else
         return v[COV_W-1:0];
   endfunction

   lane_state_type              state_ff, state_in;
   op_type                      op_ff, op_in;
   logic signed [POS_W-1:0]     meas_ff, meas_in;
   logic signed [POS_W-1:0]     x_ff, x_in, v_ff, v_in;
   logic [COV_W-1:0]            p00_ff, p00_in, p11_ff, p11_in;
   logic signed [COV_W-1:0]     p01_ff, p01_in;
   logic signed [POS_W-1:0]     hpos_ff, hpos_in, hvel_ff, hvel_in;
   logic [COV_W-1:0]            dtsq_ff, dtsq_in;
   logic signed [RES_W-1:0]     rvdt_ff, rvdt_in, rp01dt_ff, rp01dt_in;
   logic signed [RES_W-1:0]     rp11dtsq_ff, rp11dtsq_in, rp11dt_ff, rp11dt_in;
   logic [S_W-1:0]              s_ff, s_in;
   logic signed [Y_W-1:0]       y_ff, y_in;
   logic [MREG_W-1:0]           mreg_ff, mreg_in;
   logic [PROD_W-1:0]           acc_ff, acc_in;
   logic [S_W-1:0]              rem_ff, rem_in;
   logic [QUO_W-1:0]            low_ff, low_in;
   logic [QUO_W-2:0]            quo_ff, quo_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;

   logic [POS_W-1:0]            abs_v;
   logic [COV_W-1:0]            abs_p01;
   logic [Y_W-1:0]              abs_y;
   logic [COV_W-1:0]            a_op, b_op;
   logic [1:0]                  sh_sel;
   logic                        is_div, neg;
   logic [PROD_W-1:0]           bias, shifted;
   logic [QUO_W-1:0]            sh_mag, fin_mag, clamped;
   logic [S_W:0]                trial, diff;
   logic                        ge, fin;
   logic signed [RES_W-1:0]     res;
   logic signed [POS_W-1:0]     xp;
   logic [COV_W-1:0]            p00p, p11p;
   logic signed [COV_W-1:0]     p01p;
   logic [COV_W:0]              p11sum;
   logic [S_W-1:0]              s_sum;

   assign abs_v   = v_ff[POS_W-1] ? (~v_ff + 1'b1) : v_ff;
   assign abs_p01 = p01_ff[COV_W-1] ? (~p01_ff + 1'b1) : p01_ff;
   assign abs_y   = y_ff[Y_W-1] ? (~y_ff + 1'b1) : y_ff;

   // Operand selection for the current step of the sequence.
   always_comb begin
      a_op   = '0;
      b_op   = '0;
      sh_sel = SH_0;
      is_div = 1'b0;
      neg    = 1'b0;
      case (op_ff)
         OP_DTSQ: begin
            a_op = COV_W'(cfg.step_time);
            b_op = COV_W'(cfg.step_time);
         end
         OP_VDT: begin
            a_op   = COV_W'(abs_v);
            b_op   = COV_W'(cfg.step_time);
            sh_sel = SH_16;
            neg    = v_ff[POS_W-1];
         end
         OP_P01DT: begin
            a_op   = abs_p01;
            b_op   = COV_W'({cfg.step_time, 1'b0});
            sh_sel = SH_16;
            neg    = p01_ff[COV_W-1];
         end
         OP_P11DTSQ: begin
            a_op   = p11_ff;
            b_op   = dtsq_ff;
            sh_sel = SH_32;
         end
         OP_P11DT: begin
            a_op   = p11_ff;
            b_op   = COV_W'(cfg.step_time);
            sh_sel = SH_16;
         end
         OP_GX: begin
            a_op   = p00_ff;
            b_op   = COV_W'(abs_y);
            is_div = 1'b1;
            neg    = y_ff[Y_W-1];
         end
         OP_GV: begin
            a_op   = abs_p01;
            b_op   = COV_W'(abs_y);
            is_div = 1'b1;
            neg    = p01_ff[COV_W-1] ^ y_ff[Y_W-1];
         end
         OP_P11G: begin
            a_op   = abs_p01;
            b_op   = abs_p01;
            is_div = 1'b1;
         end
         OP_P00G: begin
            a_op   = p00_ff;
            b_op   = cfg.meas_var;
            is_div = 1'b1;
         end
         OP_P01G: begin
            a_op   = abs_p01;
            b_op   = cfg.meas_var;
            is_div = 1'b1;
            neg    = p01_ff[COV_W-1];
         end
         default: begin
            a_op = '0;
         end
      endcase
   end

   always_comb begin
      if (is_div)
         bias = PROD_W'(s_ff >> 1);
      else begin
         case (sh_sel)
            SH_16:   bias = PROD_W'(1) << 15;
            SH_32:   bias = PROD_W'(1) << 31;
            default: bias = '0;
         endcase
      end
      case (sh_sel)
         SH_16:   shifted = acc_ff >> 16;
         SH_32:   shifted = acc_ff >> 32;
         default: shifted = acc_ff;
      endcase
   end

   assign sh_mag = (|shifted[PROD_W-1:QUO_W]) ? '1 : shifted[QUO_W-1:0];
   assign trial  = {rem_ff, low_ff[QUO_W-1]};
   assign diff   = trial - {1'b0, s_ff};
   assign ge     = (trial >= {1'b0, s_ff});

   // Finished magnitude of the current step; it is clamped to 2^60 before signing.
   always_comb begin
      fin     = 1'b0;
      fin_mag = '0;
      if (state_ff == ST_POST) begin
         if (!is_div) begin
            fin     = 1'b1;
            fin_mag = sh_mag;
         end else if (S_W'(acc_ff[PROD_W-1:QUO_W]) >= s_ff) begin
            fin     = 1'b1;
            fin_mag = '1;
         end
      end else if (state_ff == ST_DIV && cnt_ff == '0) begin
         fin     = 1'b1;
         fin_mag = {quo_ff, ge};
      end
   end

   assign clamped = fin_mag[QUO_W-1] ? (QUO_W'(1) << (QUO_W-1)) : fin_mag;
   assign res     = neg ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});

   // Predicted state and covariance from the stored products.
   always_comb begin
      xp     = sat_s32(64'(x_ff) + 64'(rvdt_ff));
      p00p   = sat_u48($signed({16'd0, p00_ff}) + 64'(rp01dt_ff) + 64'(rp11dtsq_ff)
                       + $signed({16'd0, cfg.q_pos}));
      p01p   = sat_s48(64'(p01_ff) + 64'(rp11dt_ff) + $signed({16'd0, cfg.q_cross}));
      p11sum = {1'b0, p11_ff} + {1'b0, cfg.q_vel};
      p11p   = p11sum[COV_W] ? '1 : p11sum[COV_W-1:0];
      s_sum  = {1'b0, p00p} + {1'b0, cfg.meas_var};
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      meas_in     = meas_ff;
      x_in        = x_ff;
      v_in        = v_ff;
      p00_in      = p00_ff;
      p01_in      = p01_ff;
      p11_in      = p11_ff;
      hpos_in     = hpos_ff;
      hvel_in     = hvel_ff;
      dtsq_in     = dtsq_ff;
      rvdt_in     = rvdt_ff;
      rp01dt_in   = rp01dt_ff;
      rp11dtsq_in = rp11dtsq_ff;
      rp11dt_in   = rp11dt_ff;
      s_in        = s_ff;
      y_in        = y_ff;
      mreg_in     = mreg_ff;
      acc_in      = acc_ff;
      rem_in      = rem_ff;
      low_in      = low_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;

      if (ctl.load_meas)
         meas_in = meas;
      if (ctl.init) begin
         x_in   = meas;
         v_in   = '0;
         p00_in = COV_INIT;
         p01_in = '0;
         p11_in = COV_INIT;
      end

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               state_in = ST_MUL_LO;
               op_in    = OP_DTSQ;
            end
         end
         ST_MUL_LO: begin
            mreg_in  = a_op * b_op[HALF-1:0];
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = PROD_W'(mreg_ff);
            mreg_in  = a_op * b_op[COV_W-1:HALF];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + (PROD_W'(mreg_ff) << HALF) + bias;
            state_in = ST_POST;
         end
         ST_POST: begin
            if (is_div && !fin) begin
               rem_in   = S_W'(acc_ff[PROD_W-1:QUO_W]);
               low_in   = acc_ff[QUO_W-1:0];
               quo_in   = '0;
               cnt_in   = CNT_W'(QUO_W-1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[S_W-1:0] : trial[S_W-1:0];
            low_in = low_ff << 1;
            quo_in = {quo_ff[QUO_W-3:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end
         ST_SUMS: begin
            x_in    = xp;
            p00_in  = p00p;
            p01_in  = p01p;
            p11_in  = p11p;
            hpos_in = xp;
            hvel_in = v_ff;
            s_in    = s_sum;
            y_in    = Y_W'(meas_ff) - Y_W'(xp);
            // With zero innovation variance the prediction stands as the new state.
            if (s_sum == '0)
               state_in = ST_IDLE;
            else begin
               op_in    = OP_GX;
               state_in = ST_MUL_LO;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         state_in = ST_MUL_LO;
         case (op_ff)
            OP_DTSQ: begin
               dtsq_in = res[COV_W-1:0];
               op_in   = OP_VDT;
            end
            OP_VDT: begin
               rvdt_in = res;
               op_in   = OP_P01DT;
            end
            OP_P01DT: begin
               rp01dt_in = res;
               op_in     = OP_P11DTSQ;
            end
            OP_P11DTSQ: begin
               rp11dtsq_in = res;
               op_in       = OP_P11DT;
            end
            OP_P11DT: begin
               rp11dt_in = res;
               state_in  = ST_SUMS;
            end
            OP_GX: begin
               x_in  = sat_s32(64'(x_ff) + 64'(res));
               op_in = OP_GV;
            end
            OP_GV: begin
               v_in  = sat_s32(64'(v_ff) + 64'(res));
               op_in = OP_P11G;
            end
            OP_P11G: begin
               p11_in = sat_u48($signed({16'd0, p11_ff}) - 64'(res));
               op_in  = OP_P00G;
            end
            OP_P00G: begin
               p00_in = sat_u48(64'(res));
               op_in  = OP_P01G;
            end
            OP_P01G: begin
               p01_in   = sat_s48(64'(res));
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_DTSQ;
         meas_ff  <= '0;
         x_ff     <= '0;
         v_ff     <= '0;
         p00_ff   <= '0;
         p01_ff   <= '0;
         p11_ff   <= '0;
         hpos_ff  <= '0;
         hvel_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         meas_ff  <= meas_in;
         x_ff     <= x_in;
         v_ff     <= v_in;
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p11_ff   <= p11_in;
         hpos_ff  <= hpos_in;
         hvel_ff  <= hvel_in;
      end
      dtsq_ff     <= dtsq_in;
      rvdt_ff     <= rvdt_in;
      rp01dt_ff   <= rp01dt_in;
      rp11dtsq_ff <= rp11dtsq_in;
      rp11dt_ff   <= rp11dt_in;
      s_ff        <= s_in;
      y_ff        <= y_in;
      mreg_ff     <= mreg_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
   end

   assign busy     = (state_ff != ST_IDLE);
   assign held_pos = hpos_ff;
   assign held_vel = hvel_ff;

endmodule

/* rtl/core/kalman_position_tracker_3d.sv */
// Three-axis constant-velocity position tracker: control, registers and result merge.
// While tracking, each accepted beat runs five products (four of them shifted) and up to
// five 61-bit quotients per axis, all three axes in parallel; when not tracking no lane
// work is done. One beat is taken at a time: the next waits until the result is loaded.
// Reset is synchronous and active high; it restores the register defaults and clears state.
`timescale 1ns / 1ps

module kalman_position_tracker_3d (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [kpt_pkg::POS_W-1:0]       req_meas_x,
   input  logic signed [kpt_pkg::POS_W-1:0]       req_meas_y,
   input  logic signed [kpt_pkg::POS_W-1:0]       req_meas_z,
   input  logic                                   req_meas_valid,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_pos_x,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_vel_x,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_pos_y,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_vel_y,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_pos_z,
   output logic signed [kpt_pkg::POS_W-1:0]       rsp_pred_vel_z,
   output logic                                   rsp_track_valid,
   input  logic                                   csr_wr_en,
   input  logic [kpt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [kpt_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import kpt_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_OUT} top_state_type;

   top_state_type              state_ff, state_in;
   logic                       tracking_ff, tracking_in;
   logic [LIM_W-1:0]           miss_ff, miss_in;
   logic [LIM_W-1:0]           lost_limit_ff;
   kpt_cfg_type                cfg_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       trk_ff, trk_in;
   logic signed [POS_W-1:0]    pos_ff [NUM_AXES];
   logic signed [POS_W-1:0]    vel_ff [NUM_AXES];

   logic signed [POS_W-1:0]    meas_arr [NUM_AXES];
   logic signed [POS_W-1:0]    held_pos [NUM_AXES];
   logic signed [POS_W-1:0]    held_vel [NUM_AXES];
   logic [NUM_AXES-1:0]        lane_busy;
   kpt_lane_ctl_type           lane_ctl;
   logic                       accept, load_out;
   logic                       trk_mid;

   assign meas_arr[0] = req_meas_x;
   assign meas_arr[1] = req_meas_y;
   assign meas_arr[2] = req_meas_z;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      tracking_in  = tracking_ff;
      miss_in      = miss_ff;
      trk_mid      = tracking_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      trk_in       = trk_ff;

      lane_ctl.start     = (state_ff == ST_START);
      lane_ctl.load_meas = accept && req_meas_valid;
      lane_ctl.init      = accept && req_meas_valid && !tracking_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_meas_valid) begin
                  miss_in = '0;
                  trk_mid = 1'b1;
               end else if (miss_ff != '1)
                  miss_in = miss_ff + 1'b1;
               tracking_in = trk_mid && (miss_in < lost_limit_ff);
               state_in    = tracking_in ? ST_START : ST_OUT;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (lane_busy == '0)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               trk_in       = tracking_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         tracking_ff        <= 1'b0;
         miss_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
         cfg_ff.step_time   <= DT_W'(1311);
         cfg_ff.q_pos       <= COV_W'(17);
         cfg_ff.q_cross     <= COV_W'(1678);
         cfg_ff.q_vel       <= COV_W'(167772);
         cfg_ff.meas_var    <= COV_W'(419430400);
         lost_limit_ff      <= LIM_W'(100);
      end else begin
         state_ff     <= state_in;
         tracking_ff  <= tracking_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STEP_TIME:  cfg_ff.step_time <= csr_wdata[DT_W-1:0];
               CSR_Q_POS:      cfg_ff.q_pos     <= csr_wdata[COV_W-1:0];
               CSR_Q_CROSS:    cfg_ff.q_cross   <= csr_wdata[COV_W-1:0];
               CSR_Q_VEL:      cfg_ff.q_vel     <= csr_wdata[COV_W-1:0];
               CSR_MEAS_VAR:   cfg_ff.meas_var  <= csr_wdata[COV_W-1:0];
               CSR_LOST_LIMIT: lost_limit_ff    <= csr_wdata[LIM_W-1:0];
               default: begin
                  lost_limit_ff <= lost_limit_ff;
               end
            endcase
         end
      end
      trk_ff <= trk_in;
      // The result beat gathers every lane's held prediction at once.
      for (int i = 0; i < NUM_AXES; i++) begin
         if (load_out) begin
            pos_ff[i] <= held_pos[i];
            vel_ff[i] <= held_vel[i];
         end
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      kpt_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .cfg      (cfg_ff),
         .meas     (meas_arr[g]),
         .busy     (lane_busy[g]),
         .held_pos (held_pos[g]),
         .held_vel (held_vel[g])
      );
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pred_pos_x  = pos_ff[0];
   assign rsp_pred_vel_x  = vel_ff[0];
   assign rsp_pred_pos_y  = pos_ff[1];
   assign rsp_pred_vel_y  = vel_ff[1];
   assign rsp_pred_pos_z  = pos_ff[2];
   assign rsp_pred_vel_z  = vel_ff[2];
   assign rsp_track_valid = trk_ff;

endmodule

/* rtl/core/kpt_checker.sv */
// Port-level checks for the position tracker, bound to the top level.
`timescale 1ns / 1ps

module kpt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [kpt_pkg::POS_W-1:0]  rsp_pred_pos_x,
   input logic                              rsp_track_valid
);

   // Once a beat is taken the block works on it and takes no other.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accepted beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pred_pos_x)
                                 && $stable(rsp_track_valid))
      else $error("stalled result beat changed");

   // A result only appears as the busy period of an item ends.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   a_result_on_release: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("input reopened without a result beat");

endmodule

bind kalman_position_tracker_3d kpt_checker u_kpt_checker (.*);

/* tb/sv/kalman_position_tracker_3d_test.sv */
// Self-checking testbench for the three-axis Kalman position tracker.
`timescale 1ns / 1ps

module kalman_position_tracker_3d_test;
   import kpt_pkg::*;

   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint WIDE_LIM    = 64'h1000000000000000;
   localparam longint U48_MAX     = 64'hFFFFFFFFFFFF;
   localparam longint S48_LO      = -64'sd140737488355328;
   localparam longint S48_HI      = 64'sd140737488355327;
   localparam longint S32_LO      = -64'sd2147483648;
   localparam longint S32_HI      = 64'sd2147483647;
   localparam longint DEF_STEP    = 1311;
   localparam longint DEF_QPOS    = 17;
   localparam longint DEF_QCROSS  = 1678;
   localparam longint DEF_QVEL    = 167772;
   localparam longint DEF_RVAR    = 419430400;
   localparam longint DEF_LIMIT   = 100;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] vel_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] vel_y;
      logic [POS_W-1:0] pos_z;
      logic [POS_W-1:0] vel_z;
      logic             track;
   } track_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_meas_x = '0;
   logic signed [POS_W-1:0] req_meas_y = '0;
   logic signed [POS_W-1:0] req_meas_z = '0;
   logic req_meas_valid = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_pred_pos_x, rsp_pred_vel_x;
   logic signed [POS_W-1:0] rsp_pred_pos_y, rsp_pred_vel_y;
   logic signed [POS_W-1:0] rsp_pred_pos_z, rsp_pred_vel_z;
   logic rsp_track_valid;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   kalman_position_tracker_3d i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_meas_x(req_meas_x), .req_meas_y(req_meas_y), .req_meas_z(req_meas_z),
      .req_meas_valid(req_meas_valid),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pred_pos_x(rsp_pred_pos_x), .rsp_pred_vel_x(rsp_pred_vel_x),
      .rsp_pred_pos_y(rsp_pred_pos_y), .rsp_pred_vel_y(rsp_pred_vel_y),
      .rsp_pred_pos_z(rsp_pred_pos_z), .rsp_pred_vel_z(rsp_pred_vel_z),
      .rsp_track_valid(rsp_track_valid),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Tracker copy kept by the testbench.
   longint cfg_step, cfg_qpos, cfg_qcross, cfg_qvel, cfg_rvar, cfg_limit;
   bit     trk_on;
   longint trk_misses;
   longint trk_meas[3];
   longint trk_state[6];
   longint trk_cov[9];
   longint trk_held[6];

   track_result_type pending_predictions[$];
   int  mismatches = 0;
   int  frames_sent = 0;
   int  results_seen = 0;
   int  tracked_results = 0;
   int  config_phases = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;
   int  hold_count = 0;
   longint cycles = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic logic [63:0] magnitude(longint a);
      return a < 0 ? 64'(-a) : 64'(a);
   endfunction

   function automatic longint signed_clip(logic [63:0] m, bit neg, longint lo, longint hi);
      if (neg) return (m > 64'(-lo)) ? lo : -longint'(m);
      return (m > 64'(hi)) ? hi : longint'(m);
   endfunction

   // Product rounded to nearest (ties away from zero) after a right shift.
   function automatic longint mul_round_shift(longint a, longint b, int sh,
                                              longint lo, longint hi);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      p = p + (128'd1 << (sh - 1));
      q = p >> sh;
      return signed_clip(q[127:64] != 0 ? '1 : q[63:0], (a < 0) != (b < 0), lo, hi);
   endfunction

   function automatic longint mul_round_div(longint a, longint b, longint d,
                                            longint lo, longint hi);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
      p = p + 128'(d >> 1);
      q = p / 128'(d);
      return signed_clip(q[127:64] != 0 ? '1 : q[63:0], (a < 0) != (b < 0), lo, hi);
   endfunction

   task automatic filter_axis(int a);
      longint x, v, p00, p01, p11, xp, p00p, p01p, p11p, s, y;
      x = trk_state[2*a];
      v = trk_state[2*a+1];
      p00 = trk_cov[3*a];
      p01 = trk_cov[3*a+1];
      p11 = trk_cov[3*a+2];
      xp = clip(x + mul_round_shift(v, cfg_step, 16, -WIDE_LIM, WIDE_LIM), S32_LO, S32_HI);
      p00p = clip(p00 + mul_round_shift(p01, 2 * cfg_step, 16, -WIDE_LIM, WIDE_LIM)
                  + mul_round_shift(p11, cfg_step * cfg_step, 32, -WIDE_LIM, WIDE_LIM)
                  + cfg_qpos, 0, U48_MAX);
      p01p = clip(p01 + mul_round_shift(p11, cfg_step, 16, -WIDE_LIM, WIDE_LIM) + cfg_qcross,
                  S48_LO, S48_HI);
      p11p = clip(p11 + cfg_qvel, 0, U48_MAX);
      trk_held[2*a] = xp;
      trk_held[2*a+1] = v;
      s = p00p + cfg_rvar;
      if (s > 0) begin
         y = trk_meas[a] - xp;
         trk_state[2*a] = clip(xp + mul_round_div(p00p, y, s, -WIDE_LIM, WIDE_LIM),
                               S32_LO, S32_HI);
         trk_state[2*a+1] = clip(v + mul_round_div(p01p, y, s, -WIDE_LIM, WIDE_LIM),
                                 S32_LO, S32_HI);
         trk_cov[3*a] = mul_round_div(p00p, cfg_rvar, s, 0, U48_MAX);
         trk_cov[3*a+1] = mul_round_div(p01p, cfg_rvar, s, S48_LO, S48_HI);
         trk_cov[3*a+2] = clip(p11p - mul_round_div(p01p, p01p, s, 0, WIDE_LIM), 0, U48_MAX);
      end else begin
         // No innovation variance: keep the prediction as it is.
         trk_state[2*a] = xp;
         trk_state[2*a+1] = v;
         trk_cov[3*a] = p00p;
         trk_cov[3*a+1] = p01p;
         trk_cov[3*a+2] = p11p;
      end
   endtask

   task automatic predict_frame(input logic [31:0] mx, my, mz, input bit mv,
                                output track_result_type r);
      if (mv) begin
         trk_meas[0] = longint'($signed(mx));
         trk_meas[1] = longint'($signed(my));
         trk_meas[2] = longint'($signed(mz));
         trk_misses = 0;
         if (!trk_on) begin
            for (int a = 0; a < 3; a++) begin
               trk_state[2*a] = trk_meas[a];
               trk_state[2*a+1] = 0;
               trk_cov[3*a] = longint'(COV_INIT);
               trk_cov[3*a+1] = 0;
               trk_cov[3*a+2] = longint'(COV_INIT);
            end
         end
         trk_on = 1'b1;
      end else if (trk_misses < 65535) begin
         trk_misses++;
      end
      if (trk_misses >= cfg_limit) trk_on = 1'b0;
      if (trk_on) for (int a = 0; a < 3; a++) filter_axis(a);
      r.pos_x = trk_held[0][31:0];
      r.vel_x = trk_held[1][31:0];
      r.pos_y = trk_held[2][31:0];
      r.vel_y = trk_held[3][31:0];
      r.pos_z = trk_held[4][31:0];
      r.vel_z = trk_held[5][31:0];
      r.track = trk_on;
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, field, got, want);
      mismatches++;
   endtask

   // One frame beat; the last beat of a burst drops valid so nothing stale is taken.
   task automatic send_frame(logic [31:0] mx, my, mz, bit mv, bit last);
      track_result_type r;
      bit gap;
      req_meas_x <= mx;
      req_meas_y <= my;
      req_meas_z <= mz;
      req_meas_valid <= mv;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_frame(mx, my, mz, mv, r);
      pending_predictions.push_back(r);
      frames_sent++;
      gap = sender_gaps && ($urandom_range(0, 3) == 0);
      if (gap || last) req_valid <= 1'b0;
      if (gap) repeat ($urandom_range(1, 19)) @(posedge clock);
   endtask

   // Write enable stays high across a run of writes; the caller lowers it.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_STEP_TIME:  cfg_step = longint'(value[DT_W-1:0]);
         CSR_Q_POS:      cfg_qpos = longint'(value);
         CSR_Q_CROSS:    cfg_qcross = longint'(value);
         CSR_Q_VEL:      cfg_qvel = longint'(value);
         CSR_MEAS_VAR:   cfg_rvar = longint'(value);
         CSR_LOST_LIMIT: cfg_limit = longint'(value[LIM_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_config(longint st, qp, qc, qv, rv, lim);
      while (pending_predictions.size() != 0) @(posedge clock);
      write_reg(CSR_STEP_TIME, CSR_DATA_W'(st));
      write_reg(CSR_Q_POS, CSR_DATA_W'(qp));
      write_reg(CSR_Q_CROSS, CSR_DATA_W'(qc));
      write_reg(CSR_Q_VEL, CSR_DATA_W'(qv));
      write_reg(CSR_MEAS_VAR, CSR_DATA_W'(rv));
      write_reg(CSR_LOST_LIMIT, CSR_DATA_W'(lim));
      csr_wr_en <= 1'b0;
      config_phases++;
   endtask

   function automatic longint pick_cov(longint dflt);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return U48_MAX;
         2: return dflt;
         3: return longint'({$urandom, $urandom}) & U48_MAX;
         default: return longint'($urandom_range(0, 32'h7FFFFFFF)) >> $urandom_range(0, 20);
      endcase
   endfunction

   task automatic randomize_config();
      longint st, lim;
      case ($urandom_range(0, 4))
         0: st = 0;
         1: st = 24'hFFFFFF;
         2: st = DEF_STEP;
         default: st = $urandom_range(0, 24'h03FFFF);
      endcase
      case ($urandom_range(0, 7))
         0: lim = 0;
         1: lim = 65535;
         2: lim = DEF_LIMIT;
         default: lim = $urandom_range(1, 12);
      endcase
      set_config(st, pick_cov(DEF_QPOS), pick_cov(DEF_QCROSS), pick_cov(DEF_QVEL),
                 pick_cov(DEF_RVAR), lim);
   endtask

   // Extremes of the sample fields, misses and the start of a track at reset settings.
   task automatic test_directed_defaults();
      send_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);
      send_frame(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1, 1'b0);
      send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_frame(32'h1234_5678, 32'h8765_4321, 32'h5555_AAAA, 1'b1, 1'b1);
   endtask

   // Limit one drops on each miss; limit zero drops even on a valid sample.
   task automatic test_lost_limits();
      set_config(DEF_STEP, DEF_QPOS, DEF_QCROSS, DEF_QVEL, DEF_RVAR, 1);
      send_frame(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 1'b1, 1'b0);
      send_frame(32'h0011_0000, 32'h0021_0000, 32'h0031_0000, 1'b0, 1'b0);
      send_frame(32'h0012_0000, 32'h0022_0000, 32'h0032_0000, 1'b1, 1'b1);
      set_config(DEF_STEP, DEF_QPOS, DEF_QCROSS, DEF_QVEL, DEF_RVAR, 0);
      send_frame(32'h0013_0000, 32'h0023_0000, 32'h0033_0000, 1'b1, 1'b0);
      send_frame(32'h0014_0000, 32'h0024_0000, 32'h0034_0000, 1'b0, 1'b1);
   endtask

   // With no step, no process noise and no measurement noise the variance goes to zero.
   task automatic test_zero_innovation();
      set_config(0, 0, 0, 0, 0, 3);
      send_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      send_frame(32'h0100_0000, 32'hFF00_0000, 32'h0000_8000, 1'b1, 1'b0);
      send_frame(32'h0200_0000, 32'hFE00_0000, 32'h0001_8000, 1'b1, 1'b0);
      send_frame(32'h0300_0000, 32'hFD00_0000, 32'h0002_8000, 1'b1, 1'b1);
   endtask

   // Largest step and noise values push the covariance terms into saturation.
   task automatic test_saturation();
      set_config(24'hFFFFFF, U48_MAX, U48_MAX, U48_MAX, U48_MAX, 65535);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
      send_frame(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0);
      send_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
   endtask

   // Mostly smooth tracks with occasional noise samples and runs of misses.
   task automatic run_tracks(int n);
      longint pos[3];
      longint vel[3];
      int miss_run;
      logic [31:0] f[3];
      bit mv;
      miss_run = 0;
      for (int a = 0; a < 3; a++) begin
         pos[a] = longint'($signed($urandom));
         vel[a] = longint'($signed($urandom_range(0, 32'h3FFFF))) - 32'h1FFFF;
      end
      for (int i = 0; i < n; i++) begin
         int r;
         r = $urandom_range(0, 99);
         if (miss_run == 0 && r < 3) miss_run = $urandom_range(1, 14);
         for (int a = 0; a < 3; a++) begin
            pos[a] = clip(pos[a] + vel[a] + ($urandom_range(0, 4095) - 2048), S32_LO, S32_HI);
            f[a] = (r >= 92) ? $urandom : pos[a][31:0];
         end
         if (miss_run > 0) begin
            mv = 1'b0;
            miss_run--;
         end else begin
            mv = (r >= 10);
         end
         send_frame(f[0], f[1], f[2], mv, i == n - 1);
      end
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 7; p++) begin
         randomize_config();
         run_tracks(200);
      end
   endtask

   // The receiver holds off long enough that the block fills and stalls its input.
   task automatic test_backpressure();
      set_config(DEF_STEP, DEF_QPOS, DEF_QCROSS, DEF_QVEL, DEF_RVAR, DEF_LIMIT);
      hold_count = 3000;
      run_tracks(20);
   endtask

   task automatic test_quiet_tail();
      set_config(DEF_STEP, DEF_QPOS, DEF_QCROSS, DEF_QVEL, DEF_RVAR, 4);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_tracks(150);
   endtask

   // Long receiver hold-off, counted down one cycle at a time.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_count > 0) hold_count--;
      end
   end

   // Result checker and receiver stall pattern.
   int rcv_burst = 0;
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            track_result_type w;
            results_seen++;
            if (pending_predictions.size() == 0) begin
               $display("MISMATCH result %0d arrived with nothing expected", results_seen);
               mismatches++;
            end else begin
               w = pending_predictions.pop_front();
               if (rsp_pred_pos_x !== w.pos_x) report_mismatch("pred_pos_x", rsp_pred_pos_x, w.pos_x);
               if (rsp_pred_vel_x !== w.vel_x) report_mismatch("pred_vel_x", rsp_pred_vel_x, w.vel_x);
               if (rsp_pred_pos_y !== w.pos_y) report_mismatch("pred_pos_y", rsp_pred_pos_y, w.pos_y);
               if (rsp_pred_vel_y !== w.vel_y) report_mismatch("pred_vel_y", rsp_pred_vel_y, w.vel_y);
               if (rsp_pred_pos_z !== w.pos_z) report_mismatch("pred_pos_z", rsp_pred_pos_z, w.pos_z);
               if (rsp_pred_vel_z !== w.vel_z) report_mismatch("pred_vel_z", rsp_pred_vel_z, w.vel_z);
               if (rsp_track_valid !== w.track)
                  report_mismatch("track_valid", 32'(rsp_track_valid), 32'(w.track));
               if (w.track) tracked_results++;
            end
         end
         if (hold_count > 0) begin
            rsp_stall <= 1'b1;
         end else if (receiver_gaps && rcv_burst == 0 && $urandom_range(0, 7) == 0) begin
            rcv_burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
         end else if (rcv_burst > 0) begin
            rcv_burst--;
            rsp_stall <= (rcv_burst != 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      cfg_step = DEF_STEP;
      cfg_qpos = DEF_QPOS;
      cfg_qcross = DEF_QCROSS;
      cfg_qvel = DEF_QVEL;
      cfg_rvar = DEF_RVAR;
      cfg_limit = DEF_LIMIT;
      trk_on = 1'b0;
      trk_misses = 0;
      foreach (trk_meas[i]) trk_meas[i] = 0;
      foreach (trk_state[i]) trk_state[i] = 0;
      foreach (trk_cov[i]) trk_cov[i] = 0;
      foreach (trk_held[i]) trk_held[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_defaults();
      test_lost_limits();
      test_zero_innovation();
      test_saturation();
      test_random_phases();
      test_backpressure();
      test_quiet_tail();
      while (pending_predictions.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d frames over %0d register settings; %0d results checked, %0d tracking.",
               frames_sent, config_phases, results_seen, tracked_results);
      if (mismatches == 0 && pending_predictions.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_predictions.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/kpt_pkg.sv
rtl/core/kpt_lane.sv
rtl/core/kalman_position_tracker_3d.sv
rtl/core/kpt_checker.sv
tb/sv/kalman_position_tracker_3d_test.sv
